// ----- design/playfair_digraph_cipher_defines.svh -----
// ----------------------------------------------------------------------------
// Playfair digraph cipher: assertion macros
// Clocked assertion helpers for the cipher RTL; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH
`define PLAYFAIR_DIGRAPH_CIPHER_DEFINES_SVH

`ifndef SYNTHESIS
`define PDC_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define PDC_ASSERT(lbl, prop, msg)
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

// ----- design/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// Playfair cipher package
// Shared types, codes and key-square cell arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pfc_pkg;

    localparam int SQ_DIM   = 5;
    localparam int SQ_CELLS = SQ_DIM * SQ_DIM;

    localparam logic [4:0] LET_COUNT = 5'd26;
    localparam logic [4:0] LET_I     = 5'd8;
    localparam logic [4:0] LET_J     = 5'd9;
    localparam logic [4:0] CELL_FULL = 5'(SQ_CELLS);

    typedef enum logic [1:0] {
        CMD_KEY    = 2'd0,
        CMD_FINISH = 2'd1,
        CMD_ENC    = 2'd2,
        CMD_DEC    = 2'd3
    } t_cmd;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_KEY   = 2'd1;
    localparam logic [1:0] ST_NOT_SQ   = 2'd2;
    localparam logic [1:0] ST_KEY_SKIP = 2'd3;

    localparam logic [2:0] DIR_RIGHT = 3'd1;
    localparam logic [2:0] DIR_LEFT  = 3'd2;
    localparam logic [2:0] DIR_UP    = 3'd3;
    localparam logic [2:0] DIR_DOWN  = 3'd4;

    localparam logic CFG_ROW_DIR = 1'b0;
    localparam logic CFG_COL_DIR = 1'b1;

    typedef struct packed {
        logic [2:0] row;
        logic [2:0] col;
        logic [4:0] row_mv;
        logic [4:0] col_mv;
    } t_lane_res;

    function automatic logic [4:0] cell_of(input logic [2:0] row, input logic [2:0] col);
        return 5'({2'b00, row} * 5'(SQ_DIM) + {2'b00, col});
    endfunction

    function automatic logic [2:0] cell_row(input logic [4:0] pos);
        logic [2:0] row;
        if (pos >= 5'(4 * SQ_DIM)) begin
            row = 3'd4;
        end else if (pos >= 5'(3 * SQ_DIM)) begin
            row = 3'd3;
        end else if (pos >= 5'(2 * SQ_DIM)) begin
            row = 3'd2;
        end else if (pos >= 5'(SQ_DIM)) begin
            row = 3'd1;
        end else begin
            row = 3'd0;
        end
        return row;
    endfunction

    function automatic logic [2:0] cell_col(input logic [4:0] pos);
        logic [4:0] base;
        base = cell_of(cell_row(pos), 3'd0);
        return 3'(pos - base);
    endfunction

    function automatic logic [4:0] move_cell(input logic [4:0] pos, input logic [2:0] dir);
        logic [2:0] r;
        logic [2:0] c;
        r = cell_row(pos);
        c = cell_col(pos);
        unique case (dir)
            DIR_RIGHT: c = (c == 3'(SQ_DIM - 1)) ? 3'd0 : c + 3'd1;
            DIR_LEFT:  c = (c == 3'd0) ? 3'(SQ_DIM - 1) : c - 3'd1;
            DIR_UP:    r = (r == 3'd0) ? 3'(SQ_DIM - 1) : r - 3'd1;
            DIR_DOWN:  r = (r == 3'(SQ_DIM - 1)) ? 3'd0 : r + 3'd1;
            default:   ;
        endcase
        return cell_of(r, c);
    endfunction

endpackage

`default_nettype wire

// ----- design/pfc_lane.sv -----
// ----------------------------------------------------------------------------
// Playfair cipher lane
// Splits one letter's cell into row and column and forms its shifted cells.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfc_lane
    import pfc_pkg::*;
(
    input  wire logic [4:0] i_cell,
    input  wire logic [2:0] i_dir_row,
    input  wire logic [2:0] i_dir_col,
    output t_lane_res       o_res
);

    always_comb begin
        o_res.row    = cell_row(i_cell);
        o_res.col    = cell_col(i_cell);
        o_res.row_mv = move_cell(i_cell, i_dir_row);
        o_res.col_mv = move_cell(i_cell, i_dir_col);
    end

endmodule

`default_nettype wire

// ----- design/pfc_merge.sv -----
// ----------------------------------------------------------------------------
// Playfair cipher merge
// Picks same-row, same-column or corner cells from the two lane results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pfc_merge
    import pfc_pkg::*;
(
    input  wire t_lane_res       i_lane_a,
    input  wire t_lane_res       i_lane_b,
    output logic           [4:0] o_cell_a,
    output logic           [4:0] o_cell_b
);

    always_comb begin
        priority if (i_lane_a.row == i_lane_b.row) begin
            o_cell_a = i_lane_a.row_mv;
            o_cell_b = i_lane_b.row_mv;
        end else if (i_lane_a.col == i_lane_b.col) begin
            o_cell_a = i_lane_a.col_mv;
            o_cell_b = i_lane_b.col_mv;
        end else begin
            o_cell_a = cell_of(i_lane_a.row, i_lane_b.col);
            o_cell_b = cell_of(i_lane_b.row, i_lane_a.col);
        end
    end

endmodule

`default_nettype wire

// ----- design/playfair_digraph_cipher.sv -----
// ----------------------------------------------------------------------------
// Playfair digraph cipher
// Streamed 5x5 key square build with pair encrypt and decrypt.
// ----------------------------------------------------------------------------
// One item is in work at a time. An encrypt or decrypt pair goes from accept
// to result through the input latch with letter-to-cell read, the lane/merge
// stage with key-square read, the result stage and the output register. A
// finish command walks the alphabet letter by letter, since the fill writes
// one cell a cycle through the single write port of the square and cell
// memories. The output register holds a result until taken while the next
// item is accepted.
`timescale 1ns / 1ps
`default_nettype none
`include "playfair_digraph_cipher_defines.svh"

module playfair_digraph_cipher
    import pfc_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,   // [4:0] letter_a, [9:5] letter_b, rest zero
    input  wire logic [1:0]  s_axis_tuser,   // [1:0] command
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic      [15:0] m_axis_tdata,   // [4:0] out_a, [9:5] out_b, rest zero
    output logic      [1:0]  m_axis_tuser,   // [1:0] status
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic        i_cfg_index,
    input  wire logic [2:0]  i_cfg_data
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_KEY  = 6'b000010,
        S_FILL = 6'b000100,
        S_LOOK = 6'b001000,
        S_SQ   = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

    t_state      r_state, n_state;
    logic [4:0]  r_cells, n_cells;
    logic [25:0] r_used, n_used;
    logic        r_key_ready, n_key_ready;
    logic [4:0]  r_let, n_let;
    logic        r_m_valid;
    logic [2:0]  r_row_dir, r_col_dir;

    t_cmd        r_cmd;
    logic [4:0]  r_a, r_b;
    logic [4:0]  r_cell_a, r_cell_b;
    logic [4:0]  r_sq_a, r_sq_b;
    logic [4:0]  r_res_a, r_res_b;
    logic [1:0]  r_res_st;
    logic [4:0]  r_out_a, r_out_b;
    logic [1:0]  r_out_st;

    logic [4:0]  key_square  [SQ_CELLS];
    logic [4:0]  letter_cell [26];

    logic        w_in_acc, w_cfg_acc, w_out_free;
    t_cmd        w_in_cmd;
    logic [4:0]  w_in_a, w_in_b, w_rd_a, w_rd_b;
    logic [25:0] w_used_eff;
    logic [4:0]  w_cells_eff;
    logic        w_key_skip;
    logic        w_place;
    logic [4:0]  w_place_let, w_place_cell;
    logic        w_res_load, w_res_pair;
    logic [1:0]  w_res_st;
    logic        w_enc;
    logic [2:0]  w_dir_row, w_dir_col;
    t_lane_res   w_lane_a, w_lane_b;
    logic [4:0]  w_na, w_nb;

    assign s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready   = 1'b1;
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'd0, r_out_b, r_out_a};
    assign m_axis_tuser  = r_out_st;

    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_cfg_acc  = i_cfg_valid && o_cfg_ready;
    assign w_out_free = !r_m_valid || m_axis_tready;

    // j folds onto i for encrypt only
    always_comb begin
        w_in_cmd = t_cmd'(s_axis_tuser);
        w_in_a   = s_axis_tdata[4:0];
        w_in_b   = s_axis_tdata[9:5];
        if (w_in_cmd == CMD_ENC) begin
            if (w_in_a == LET_J) begin
                w_in_a = LET_I;
            end
            if (w_in_b == LET_J) begin
                w_in_b = LET_I;
            end
        end
        w_rd_a = (w_in_a < LET_COUNT) ? w_in_a : 5'd0;
        w_rd_b = (w_in_b < LET_COUNT) ? w_in_b : 5'd0;
    end

    // a key letter after a finished key starts over
    assign w_used_eff  = r_key_ready ? 26'd0 : r_used;
    assign w_cells_eff = r_key_ready ? 5'd0 : r_cells;
    assign w_key_skip  = (r_a >= LET_COUNT) || (r_a == LET_J) || w_used_eff[r_a]
                         || (w_cells_eff >= CELL_FULL);

    assign w_enc     = (r_cmd == CMD_ENC);
    assign w_dir_row = w_enc ? r_row_dir : DIR_LEFT;
    assign w_dir_col = w_enc ? r_col_dir : DIR_UP;

    pfc_lane u_lane_a (
        .i_cell    (r_cell_a),
        .i_dir_row (w_dir_row),
        .i_dir_col (w_dir_col),
        .o_res     (w_lane_a)
    );

    pfc_lane u_lane_b (
        .i_cell    (r_cell_b),
        .i_dir_row (w_dir_row),
        .i_dir_col (w_dir_col),
        .o_res     (w_lane_b)
    );

    pfc_merge u_merge (
        .i_lane_a (w_lane_a),
        .i_lane_b (w_lane_b),
        .o_cell_a (w_na),
        .o_cell_b (w_nb)
    );

    always_comb begin
        n_state      = r_state;
        n_cells      = r_cells;
        n_used       = r_used;
        n_key_ready  = r_key_ready;
        n_let        = r_let;
        w_place      = 1'b0;
        w_place_let  = r_a;
        w_place_cell = r_cells;
        w_res_load   = 1'b0;
        w_res_pair   = 1'b0;
        w_res_st     = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_let = 5'd0;
                    unique case (w_in_cmd)
                        CMD_KEY:    n_state = S_KEY;
                        CMD_FINISH: n_state = S_FILL;
                        default:    n_state = S_LOOK;
                    endcase
                end
            end
            S_KEY: begin
                n_used       = w_used_eff;
                n_cells      = w_cells_eff;
                n_key_ready  = 1'b0;
                w_place_cell = w_cells_eff;
                w_res_load   = 1'b1;
                if (w_key_skip) begin
                    w_res_st = ST_KEY_SKIP;
                end else begin
                    w_place          = 1'b1;
                    n_used[r_a]      = 1'b1;
                    n_cells          = w_cells_eff + 5'd1;
                end
                n_state = S_DONE;
            end
            S_FILL: begin
                if ((r_let == LET_COUNT) || (r_cells >= CELL_FULL)) begin
                    n_key_ready = 1'b1;
                    w_res_load  = 1'b1;
                    n_state     = S_DONE;
                end else begin
                    w_place_let = r_let;
                    if ((r_let != LET_J) && !r_used[r_let]) begin
                        w_place       = 1'b1;
                        n_used[r_let] = 1'b1;
                        n_cells       = r_cells + 5'd1;
                    end
                    n_let = r_let + 5'd1;
                end
            end
            S_LOOK: begin
                if (!r_key_ready) begin
                    w_res_load = 1'b1;
                    w_res_st   = ST_NO_KEY;
                    n_state    = S_DONE;
                end else if ((r_a >= LET_COUNT) || (r_b >= LET_COUNT)
                             || !r_used[r_a] || !r_used[r_b]) begin
                    w_res_load = 1'b1;
                    w_res_st   = ST_NOT_SQ;
                    n_state    = S_DONE;
                end else begin
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                w_res_load = 1'b1;
                w_res_pair = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cells     <= 5'd0;
            r_used      <= 26'd0;
            r_key_ready <= 1'b0;
            r_let       <= 5'd0;
            r_m_valid   <= 1'b0;
            r_row_dir   <= DIR_RIGHT;
            r_col_dir   <= DIR_DOWN;
        end else begin
            r_state     <= n_state;
            r_cells     <= n_cells;
            r_used      <= n_used;
            r_key_ready <= n_key_ready;
            r_let       <= n_let;
            if ((r_state == S_DONE) && w_out_free) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
            if (w_cfg_acc) begin
                unique case (i_cfg_index)
                    CFG_ROW_DIR: r_row_dir <= i_cfg_data;
                    CFG_COL_DIR: r_col_dir <= i_cfg_data;
                    default:     ;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_cmd    <= w_in_cmd;
            r_a      <= w_in_a;
            r_b      <= w_in_b;
            r_cell_a <= letter_cell[w_rd_a];
            r_cell_b <= letter_cell[w_rd_b];
        end
        if (w_place) begin
            key_square[w_place_cell]  <= w_place_let;
            letter_cell[w_place_let]  <= w_place_cell;
        end
        if (r_state == S_LOOK) begin
            r_sq_a <= key_square[w_na];
            r_sq_b <= key_square[w_nb];
        end
        if (w_res_load) begin
            r_res_a  <= w_res_pair ? r_sq_a : 5'd0;
            r_res_b  <= w_res_pair ? r_sq_b : 5'd0;
            r_res_st <= w_res_st;
        end
        if ((r_state == S_DONE) && w_out_free) begin
            r_out_a  <= r_res_a;
            r_out_b  <= r_res_b;
            r_out_st <= r_res_st;
        end
    end

    `PDC_ASSERT(a_cells_max, r_cells <= CELL_FULL, "cell count past square size")
    `PDC_ASSERT(a_ready_full, r_key_ready |-> (r_cells == CELL_FULL), "key ready with open cells")
    `PDC_ASSERT(a_used_count, $countones(r_used) == int'(r_cells), "used letters differ from cells")
    `PDC_ASSERT_NEXT(a_ready_src, !r_key_ready && (r_state != S_FILL), !r_key_ready, "key ready outside fill")

endmodule

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Playfair digraph cipher testbench
// Streams key letters, finish commands and cipher pairs into the block under
// random sender bursts and receiver stalls. A scoreboard keeps its own key
// square and direction registers, predicts each result beat and compares it
// field by field against the output stream. Runs through several direction
// settings, including out-of-range codes.
// ----------------------------------------------------------------------------

module tb;
    import pfc_pkg::*;

    typedef struct packed {
        logic [4:0] out_a;
        logic [4:0] out_b;
        logic [1:0] status;
    } t_result;

    class cipher_scoreboard;
        logic [4:0] square [SQ_CELLS];
        logic [4:0] cell_of_letter [26];
        bit         placed [26];
        int         filled;
        bit         ready;
        logic [2:0] row_dir;
        logic [2:0] col_dir;
        t_result    expected_q [$];
        int         mismatches;
        int         results_seen;
        int         status_count [4];

        function new();
            foreach (placed[l]) placed[l] = 1'b0;
            foreach (status_count[s]) status_count[s] = 0;
            filled       = 0;
            ready        = 1'b0;
            row_dir      = DIR_RIGHT;
            col_dir      = DIR_DOWN;
            mismatches   = 0;
            results_seen = 0;
        endfunction

        function void set_reg(logic idx, logic [2:0] val);
            if (idx == CFG_ROW_DIR) begin
                row_dir = val;
            end else begin
                col_dir = val;
            end
        endfunction

        function void place(logic [4:0] letter);
            square[filled]         = letter;
            cell_of_letter[letter] = 5'(filled);
            placed[letter]         = 1'b1;
            filled++;
        endfunction

        function int shift_cell(int pos, logic [2:0] dir);
            int r;
            int c;
            r = pos / SQ_DIM;
            c = pos % SQ_DIM;
            case (dir)
                DIR_RIGHT: c = (c + 1) % SQ_DIM;
                DIR_LEFT:  c = (c + SQ_DIM - 1) % SQ_DIM;
                DIR_UP:    r = (r + SQ_DIM - 1) % SQ_DIM;
                DIR_DOWN:  r = (r + 1) % SQ_DIM;
                default:   ;
            endcase
            return r * SQ_DIM + c;
        endfunction

        function void note_item(t_cmd cmd, logic [4:0] a, logic [4:0] b);
            t_result    res;
            int         ca;
            int         cb;
            int         na;
            int         nb;
            logic [2:0] dir;
            bit         enc;
            res = '0;
            res.status = ST_OK;
            enc = (cmd == CMD_ENC);
            case (cmd)
                CMD_KEY: begin
                    if (ready) begin
                        foreach (placed[l]) placed[l] = 1'b0;
                        filled = 0;
                        ready  = 1'b0;
                    end
                    if (a >= LET_COUNT || a == LET_J || placed[a] || filled >= SQ_CELLS) begin
                        res.status = ST_KEY_SKIP;
                    end else begin
                        place(a);
                    end
                end
                CMD_FINISH: begin
                    for (int l = 0; l < 26 && filled < SQ_CELLS; l++) begin
                        if (l != LET_J && !placed[l]) place(5'(l));
                    end
                    ready = 1'b1;
                end
                default: begin
                    if (!ready) begin
                        res.status = ST_NO_KEY;
                    end else begin
                        if (enc && a == LET_J) a = LET_I;
                        if (enc && b == LET_J) b = LET_I;
                        if (a >= LET_COUNT || b >= LET_COUNT || !placed[a] || !placed[b]) begin
                            res.status = ST_NOT_SQ;
                        end else begin
                            ca = cell_of_letter[a];
                            cb = cell_of_letter[b];
                            if (ca / SQ_DIM == cb / SQ_DIM) begin
                                dir = enc ? row_dir : DIR_LEFT;
                                na  = shift_cell(ca, dir);
                                nb  = shift_cell(cb, dir);
                            end else if (ca % SQ_DIM == cb % SQ_DIM) begin
                                dir = enc ? col_dir : DIR_UP;
                                na  = shift_cell(ca, dir);
                                nb  = shift_cell(cb, dir);
                            end else begin
                                na = (ca / SQ_DIM) * SQ_DIM + cb % SQ_DIM;
                                nb = (cb / SQ_DIM) * SQ_DIM + ca % SQ_DIM;
                            end
                            res.out_a = square[na];
                            res.out_b = square[nb];
                        end
                    end
                end
            endcase
            status_count[res.status]++;
            expected_q = {expected_q, res};
        endfunction

        task log_mismatch(string msg);
            $display("%0t ns mismatch: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [4:0] oa, logic [4:0] ob, logic [1:0] st);
            t_result want;
            results_seen++;
            if (expected_q.size() == 0) begin
                log_mismatch($sformatf("unexpected beat a=%0d b=%0d st=%0d", oa, ob, st));
                return;
            end
            want = expected_q.pop_front();
            if (st !== want.status)
                log_mismatch($sformatf("beat %0d status %0d, want %0d",
                                       results_seen, st, want.status));
            if (oa !== want.out_a)
                log_mismatch($sformatf("beat %0d out_a %0d, want %0d",
                                       results_seen, oa, want.out_a));
            if (ob !== want.out_b)
                log_mismatch($sformatf("beat %0d out_b %0d, want %0d",
                                       results_seen, ob, want.out_b));
        endtask
    endclass

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;
    logic [1:0]  s_axis_tuser  = CMD_KEY;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        i_cfg_valid   = 1'b0;
    logic        o_cfg_ready;
    logic        i_cfg_index   = CFG_ROW_DIR;
    logic [2:0]  i_cfg_data    = '0;

    cipher_scoreboard sb;

    int items_sent;
    int key_letters_sent;
    int finishes_sent;
    int pairs_sent;
    int keys_built;
    int burst_left;
    bit gaps_on;
    bit long_hold;

    // row / column encrypt moves per phase; 0, 5, 6, 7 are out of range
    logic [2:0] row_set [8] = '{DIR_RIGHT, DIR_LEFT, DIR_DOWN, DIR_UP,
                                3'd0, 3'd5, DIR_RIGHT, DIR_DOWN};
    logic [2:0] col_set [8] = '{DIR_DOWN, DIR_UP, DIR_RIGHT, DIR_LEFT,
                                3'd7, 3'd6, DIR_RIGHT, DIR_DOWN};

    playfair_digraph_cipher uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #6 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata[4:0], m_axis_tdata[9:5], m_axis_tuser);
    end

    // receiver stall pattern, plus one long hold-off on request
    initial begin : sink
        int mode;
        int mode_left;
        mode      = 0;
        mode_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                m_axis_tready = 1'b0;
                repeat (200) @(negedge i_clk);
                long_hold = 1'b0;
            end
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 120);
            end
            mode_left--;
            case (mode)
                0:       m_axis_tready = 1'b1;
                1:       m_axis_tready = 1'($urandom_range(0, 1));
                2:       m_axis_tready = (mode_left % 5 != 0);
                default: m_axis_tready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    initial begin
        #10_000_000;
        $display("timeout with %0d beats outstanding", sb.expected_q.size());
        $display("CHECK FAILED");
        $finish;
    end

    // called and returns at a falling edge
    task automatic send_item(t_cmd cmd, logic [4:0] a, logic [4:0] b);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(1, 6) : 0;
            if (gap > 0) begin
                s_axis_tvalid = 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid = 1'b1;
        s_axis_tdata  = {6'd0, b, a};
        s_axis_tuser  = cmd;
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_item(cmd, a, b);
        items_sent++;
        burst_left--;
        case (cmd)
            CMD_KEY:    key_letters_sent++;
            CMD_FINISH: finishes_sent++;
            default:    pairs_sent++;
        endcase
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(logic idx, logic [2:0] val);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = val;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, val);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic build_key(bit full);
        logic [4:0] order [$];
        logic [4:0] tmp;
        int         j;
        if (full) begin
            // every usable letter shuffled, then letters past a full square
            for (int l = 0; l < 26; l++) begin
                if (l != LET_J) order = {order, 5'(l)};
            end
            for (int k = order.size() - 1; k > 0; k--) begin
                j        = $urandom_range(0, k);
                tmp      = order[k];
                order[k] = order[j];
                order[j] = tmp;
            end
            repeat ($urandom_range(1, 3)) order = {order, 5'($urandom_range(0, 31))};
        end else begin
            repeat ($urandom_range(0, 12)) begin
                if ($urandom_range(0, 7) == 0)
                    order = {order, 5'($urandom_range(0, 31))};
                else
                    order = {order, 5'($urandom_range(0, 25))};
            end
        end
        foreach (order[k]) send_item(CMD_KEY, order[k], 5'($urandom_range(0, 31)));
        send_item(CMD_FINISH, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        if ($urandom_range(0, 5) == 0)
            send_item(CMD_FINISH, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)));
        keys_built++;
    endtask

    // pairs biased toward same row, same column and 'j'
    task automatic send_pair();
        t_cmd       cmd;
        logic [4:0] a;
        logic [4:0] b;
        int         ca;
        int         pick;
        cmd = $urandom_range(0, 1) ? CMD_ENC : CMD_DEC;
        if (sb.ready) begin
            a    = sb.square[$urandom_range(0, SQ_CELLS - 1)];
            ca   = sb.cell_of_letter[a];
            pick = $urandom_range(0, 9);
            if (pick < 3)
                b = sb.square[(ca / SQ_DIM) * SQ_DIM + $urandom_range(0, SQ_DIM - 1)];
            else if (pick < 6)
                b = sb.square[$urandom_range(0, SQ_DIM - 1) * SQ_DIM + ca % SQ_DIM];
            else if (pick < 9)
                b = sb.square[$urandom_range(0, SQ_CELLS - 1)];
            else
                b = 5'($urandom_range(0, 31));
            if (a == LET_I && $urandom_range(0, 1)) a = LET_J;
            if (b == LET_I && $urandom_range(0, 1)) b = LET_J;
            if ($urandom_range(0, 19) == 0) a = 5'($urandom_range(0, 31));
        end else begin
            a = 5'($urandom_range(0, 31));
            b = 5'($urandom_range(0, 31));
        end
        send_item(cmd, a, b);
    endtask

    task automatic run_phase(int phase, int count);
        int stop_at;
        int pick;
        bit pressed;
        stop_at = items_sent + count;
        pressed = 1'b0;
        build_key($urandom_range(0, 2) == 0);
        while (items_sent < stop_at) begin
            if (!pressed && items_sent > stop_at - count / 2) begin
                pressed = 1'b1;
                if (phase == 2) long_hold = 1'b1;
                if (phase == 5) drain();
            end
            pick = $urandom_range(0, 99);
            if (pick < 5)
                build_key($urandom_range(0, 9) < 3);
            else if (pick < 8)
                send_item(t_cmd'($urandom_range(0, 3)), 5'($urandom_range(0, 31)),
                          5'($urandom_range(0, 31)));
            else
                send_pair();
        end
    endtask

    initial begin
        sb = new();
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        send_item(CMD_ENC, 5'd0, 5'd1);     // no key yet
        send_item(CMD_DEC, 5'd2, 5'd3);
        // p l a y f a(dup) i r j(skip) 31(skip) e
        send_item(CMD_KEY, 5'd15, 5'd0);
        send_item(CMD_KEY, 5'd11, 5'd0);
        send_item(CMD_KEY, 5'd0, 5'd0);
        send_item(CMD_KEY, 5'd24, 5'd0);
        send_item(CMD_KEY, 5'd5, 5'd0);
        send_item(CMD_KEY, 5'd0, 5'd0);
        send_item(CMD_KEY, 5'd8, 5'd0);
        send_item(CMD_KEY, 5'd17, 5'd0);
        send_item(CMD_KEY, 5'd9, 5'd0);
        send_item(CMD_KEY, 5'd31, 5'd31);
        send_item(CMD_KEY, 5'd4, 5'd0);
        send_item(CMD_FINISH, 5'd0, 5'd0);
        send_item(CMD_FINISH, 5'd31, 5'd31); // already full
        send_item(CMD_ENC, 5'd0, 5'd24);     // same row
        send_item(CMD_ENC, 5'd15, 5'd20);    // same column, wraps
        send_item(CMD_ENC, 5'd11, 5'd4);     // rectangle
        send_item(CMD_ENC, 5'd9, 5'd1);      // j folds to i
        send_item(CMD_DEC, 5'd0, 5'd24);
        send_item(CMD_DEC, 5'd15, 5'd20);
        send_item(CMD_DEC, 5'd9, 5'd0);      // j never in square
        send_item(CMD_ENC, 5'd25, 5'd30);    // out of range
        send_item(CMD_DEC, 5'd0, 5'd31);
        send_item(CMD_ENC, 5'd0, 5'd0);
        send_item(CMD_KEY, 5'd10, 5'd0);     // restarts the key

        for (int phase = 0; phase < 8; phase++) begin
            drain();
            if (phase > 0) begin
                write_reg(CFG_ROW_DIR, row_set[phase]);
                write_reg(CFG_COL_DIR, col_set[phase]);
            end
            gaps_on = phase[0];
            run_phase(phase, 240);
        end

        s_axis_tvalid = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
        if (sb.expected_q.size() != 0)
            sb.log_mismatch($sformatf("%0d beats never arrived", sb.expected_q.size()));

        $display("covered %0d items: %0d key letters, %0d finishes, %0d pairs, %0d keys built",
                 items_sent, key_letters_sent, finishes_sent, pairs_sent, keys_built);
        $display("%0d beats checked over 8 direction settings: ok %0d, no key %0d, %s %0d, %s %0d",
                 sb.results_seen, sb.status_count[ST_OK], sb.status_count[ST_NO_KEY],
                 "not in square", sb.status_count[ST_NOT_SQ],
                 "key skipped", sb.status_count[ST_KEY_SKIP]);
        if (sb.mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ----- playfair_digraph_cipher.f -----
+incdir+design
design/pfc_pkg.sv
design/pfc_lane.sv
design/pfc_merge.sv
design/playfair_digraph_cipher.sv
test/tb.sv
